// ===== rtl/rwh_pkg.sv =====
package rwh_pkg;

  localparam int COORD_W   = 16;
  localparam int COL_W     = 10;
  localparam int LEN_W     = 12;
  localparam int CNT_W     = 10;
  localparam int PARAM_W   = 13;
  localparam int DIST_W    = 17;
  localparam int BAR_X_W   = 21;
  localparam int BAR_H_W   = 18;
  localparam int SHADE_W   = 8;

  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 128;

  localparam int SCREEN_RIGHT_DEF = 2000;
  localparam int VIEW_WIDTH_DEF   = 1000;

  localparam logic [LEN_W-1:0] LEN_RESET = 12'd256;
  localparam logic [CNT_W-1:0] CNT_RESET = 10'd64;

  // 100 pixels in Q13.4
  localparam logic [DIST_W-1:0] BAR_Y_BASE = 17'd1600;
  localparam logic [SHADE_W-1:0] SHADE_MAX = 8'd255;

  localparam logic [0:0] REG_RAY_LENGTH = 1'b0;
  localparam logic [0:0] REG_RAY_COUNT  = 1'b1;

  // Pipeline depth from input register to output register.
  localparam int PIPE_DEPTH = 59;

endpackage

// ===== rtl/rwh_delay.sv =====
module rwh_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

// ===== rtl/rwh_divider.sv =====
// Restoring unsigned divider, one quotient bit per register stage.
// The quotient must fit in QW bits.
module rwh_divider #(
  parameter int NW = 24,
  parameter int DW = 16,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int XW = QW + DW;

  logic [XW-1:0] numx;
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [DW-1:0] rem_next [QW];
  logic [QW-1:0] low_next [QW];
  logic [QW-1:0] quo_next [QW];
  logic [DW-1:0] den_next [QW];

  assign numx = XW'(num);

  always_comb begin
    logic [DW-1:0] r_in;
    logic [QW-1:0] n_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        r_in = numx[XW-1:QW];
        n_in = numx[QW-1:0];
        q_in = '0;
        d_in = den;
      end else begin
        r_in = rem_q[k-1];
        n_in = low_q[k-1];
        q_in = quo_q[k-1];
        d_in = den_q[k-1];
      end
      t    = {r_in, n_in[QW-1]};
      diff = t - {1'b0, d_in};
      rem_next[k] = diff[DW] ? t[DW-1:0] : diff[DW-1:0];
      quo_next[k] = {q_in[QW-2:0], ~diff[DW]};
      low_next[k] = {n_in[QW-2:0], 1'b0};
      den_next[k] = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q <= rem_next;
      low_q <= low_next;
      quo_q <= quo_next;
      den_q <= den_next;
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ===== rtl/rwh_sqrt.sv =====
// Digit-by-digit square root, one root bit per stage, then a rounding
// stage that adds one when the remainder exceeds the root.
module rwh_sqrt #(
  parameter int RW = 17
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] radicand,
  output logic [RW-1:0]   root
);

  localparam int TW = RW + 4;

  logic [RW+1:0]   rem_q [RW];
  logic [RW-1:0]   q_q   [RW];
  logic [2*RW-1:0] s_q   [RW];
  logic [RW+1:0]   rem_next [RW];
  logic [RW-1:0]   q_next   [RW];
  logic [2*RW-1:0] s_next   [RW];
  logic [RW-1:0]   root_q;

  always_comb begin
    logic [RW+1:0]   r_in;
    logic [RW-1:0]   q_in;
    logic [2*RW-1:0] s_in;
    logic [TW-1:0]   t;
    logic [TW-1:0]   trial;
    logic            ge;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        r_in = '0;
        q_in = '0;
        s_in = radicand;
      end else begin
        r_in = rem_q[k-1];
        q_in = q_q[k-1];
        s_in = s_q[k-1];
      end
      t     = {r_in, s_in[2*RW-1:2*RW-2]};
      trial = TW'({q_in, 2'b01});
      ge    = (t >= trial);
      rem_next[k] = ge ? (RW+2)'(t - trial) : t[RW+1:0];
      q_next[k]   = {q_in[RW-2:0], ge};
      s_next[k]   = {s_in[2*RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q  <= rem_next;
      q_q    <= q_next;
      s_q    <= s_next;
      root_q <= q_q[RW-1] + RW'(rem_q[RW-1] > (RW+2)'(q_q[RW-1]));
    end
  end

  assign root = root_q;

endmodule

// ===== rtl/ray_wall_hit_column.sv =====
// Ray against wall intersection with screen column bar output.
// Input channel s_axis carries one ray segment, one wall segment, the viewer
// position and a column number per transaction. Output channel m_axis carries
// one result per input transaction, in order: the hit flag in tuser and the
// crossing point, distance, bar geometry and shade in tdata. A miss gives all zeros.
// The cfg port writes ray_length (index 0) and ray_count (index 1); write only
// while no transaction is in flight.
// The block is a 59-stage pipeline, and one item can enter every cycle while
// the output is not stalled. Most of the stages belong to the 18-step crossing
// divider, the 17-step square root and the 8-step shade divider, one bit per
// stage each.
// The whole pipeline advances as one: when the output holds a result that is
// not taken, s_axis_tready drops and every stage holds its contents.
// Reset empties the pipeline and loads ray_length 256 and ray_count 64.
module ray_wall_hit_column
  import rwh_pkg::*;
#(
  parameter logic [PARAM_W-1:0] SCREEN_RIGHT = PARAM_W'(SCREEN_RIGHT_DEF),
  parameter logic [PARAM_W-1:0] VIEW_WIDTH   = PARAM_W'(VIEW_WIDTH_DEF)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // ray_start_x, ray_start_y, ray_end_x, ray_end_y, wall_start_x,
  // wall_start_y, wall_end_x, wall_end_y, viewer_x, viewer_y, column_number
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // cross_x, cross_y, distance, bar_x, bar_y, bar_width, bar_height, shade
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // hit
  output logic                   m_axis_tuser,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [LEN_W-1:0]       cfg_data
);

  logic adv;
  logic [PIPE_DEPTH-1:0] vld;
  logic [LEN_W-1:0] ray_length;
  logic [CNT_W-1:0] ray_count;

  logic [COORD_W-1:0] rx0, ry0, rx1, ry1, wx0, wy0, wx1, wy1, vx, vy;
  logic [COL_W-1:0]   column_number;

  assign rx0 = s_axis_tdata[15:0];
  assign ry0 = s_axis_tdata[31:16];
  assign rx1 = s_axis_tdata[47:32];
  assign ry1 = s_axis_tdata[63:48];
  assign wx0 = s_axis_tdata[79:64];
  assign wy0 = s_axis_tdata[95:80];
  assign wx1 = s_axis_tdata[111:96];
  assign wy1 = s_axis_tdata[127:112];
  assign vx  = s_axis_tdata[143:128];
  assign vy  = s_axis_tdata[159:144];
  assign column_number = s_axis_tdata[169:160];

  assign adv = !vld[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_length <= LEN_RESET;
      ray_count  <= CNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAY_LENGTH: ray_length <= cfg_data;
        REG_RAY_COUNT:  ray_count  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: direction and offset vectors.
  logic signed [16:0] s1_dxr, s1_dyr, s1_dxw, s1_dyw, s1_ex, s1_ey;
  logic [COORD_W-1:0] s1_rx0, s1_ry0, s1_vx, s1_vy;
  logic [COL_W-1:0]   s1_col;
  logic [LEN_W-1:0]   s1_len;
  logic [CNT_W-1:0]   s1_cnt;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dxr <= $signed({rx1[15], rx1}) - $signed({rx0[15], rx0});
      s1_dyr <= $signed({ry1[15], ry1}) - $signed({ry0[15], ry0});
      s1_dxw <= $signed({wx1[15], wx1}) - $signed({wx0[15], wx0});
      s1_dyw <= $signed({wy1[15], wy1}) - $signed({wy0[15], wy0});
      s1_ex  <= $signed({wx0[15], wx0}) - $signed({rx0[15], rx0});
      s1_ey  <= $signed({wy0[15], wy0}) - $signed({ry0[15], ry0});
      s1_rx0 <= rx0;
      s1_ry0 <= ry0;
      s1_vx  <= vx;
      s1_vy  <= vy;
      s1_col <= column_number;
      s1_len <= ray_length;
      // A zero count is taken as one ray.
      s1_cnt <= (ray_count == '0) ? CNT_W'(1) : ray_count;
    end
  end

  // Stage 2: cross products.
  logic signed [33:0] s2_p0, s2_p1, s2_p2, s2_p3, s2_p4, s2_p5;
  logic signed [16:0] s2_dxr, s2_dyr;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p0  <= s1_dxr * s1_dyw;
      s2_p1  <= s1_dyr * s1_dxw;
      s2_p2  <= s1_ex * s1_dyw;
      s2_p3  <= s1_ey * s1_dxw;
      s2_p4  <= s1_ex * s1_dyr;
      s2_p5  <= s1_ey * s1_dxr;
      s2_dxr <= s1_dxr;
      s2_dyr <= s1_dyr;
    end
  end

  // Stage 3: determinant and the two parameter numerators.
  logic signed [34:0] s3_den, s3_tn, s3_un;
  logic signed [16:0] s3_dxr, s3_dyr;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_den <= 35'(s2_p0) - 35'(s2_p1);
      s3_tn  <= 35'(s2_p2) - 35'(s2_p3);
      s3_un  <= 35'(s2_p4) - 35'(s2_p5);
      s3_dxr <= s2_dxr;
      s3_dyr <= s2_dyr;
    end
  end

  // Stage 4: make the determinant positive and take the ray direction magnitudes.
  logic signed [34:0] s4_den, s4_tn, s4_un;
  logic               s4_nz, s4_xneg, s4_yneg;
  logic [16:0]        s4_xabs, s4_yabs;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_den  <= s3_den[34] ? -s3_den : s3_den;
      s4_tn   <= s3_den[34] ? -s3_tn : s3_tn;
      s4_un   <= s3_den[34] ? -s3_un : s3_un;
      s4_nz   <= (s3_den != '0);
      s4_xneg <= s3_dxr[16];
      s4_yneg <= s3_dyr[16];
      s4_xabs <= s3_dxr[16] ? 17'(-s3_dxr) : 17'(s3_dxr);
      s4_yabs <= s3_dyr[16] ? 17'(-s3_dyr) : 17'(s3_dyr);
    end
  end

  // Stage 5: the crossing must lie on both segments, ends included.
  logic        s5_hit, s5_xneg, s5_yneg;
  logic [33:0] s5_den, s5_tn;
  logic [16:0] s5_xabs, s5_yabs;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_hit  <= s4_nz && !s4_tn[34] && (s4_tn <= s4_den) &&
                 !s4_un[34] && (s4_un <= s4_den);
      s5_den  <= s4_den[33:0];
      s5_tn   <= s4_tn[33:0];
      s5_xneg <= s4_xneg;
      s5_yneg <= s4_yneg;
      s5_xabs <= s4_xabs;
      s5_yabs <= s4_yabs;
    end
  end

  // Stage 6: partial products of |d| * tn, split on tn.
  logic [33:0] s6_xl, s6_xh, s6_yl, s6_yh;
  logic [33:0] s6_den;
  logic        s6_xneg, s6_yneg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_xl   <= s5_xabs * s5_tn[16:0];
      s6_xh   <= s5_xabs * s5_tn[33:17];
      s6_yl   <= s5_yabs * s5_tn[16:0];
      s6_yh   <= s5_yabs * s5_tn[33:17];
      s6_den  <= s5_den;
      s6_xneg <= s5_xneg;
      s6_yneg <= s5_yneg;
    end
  end

  // Stage 7: full products.
  logic [50:0] s7_ax, s7_ay;
  logic [33:0] s7_den;
  logic        s7_xneg, s7_yneg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ax   <= 51'(s6_xl) + {s6_xh, 17'b0};
      s7_ay   <= 51'(s6_yl) + {s6_yh, 17'b0};
      s7_den  <= s6_den;
      s7_xneg <= s6_xneg;
      s7_yneg <= s6_yneg;
    end
  end

  // Stage 8: rounding numerators. Ties go up, which for a negative
  // direction means one less on the magnitude.
  logic [52:0] s8_nx, s8_ny;
  logic [34:0] s8_d2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_nx <= 53'({s7_ax, 1'b0}) + 53'(s7_den) - 53'(s7_xneg);
      s8_ny <= 53'({s7_ay, 1'b0}) + 53'(s7_den) - 53'(s7_yneg);
      s8_d2 <= {s7_den, 1'b0};
    end
  end

  logic [17:0] qx, qy;

  rwh_divider #(.NW(53), .DW(35), .QW(18)) u_div_x (
    .clk(clk), .en(adv), .num(s8_nx), .den(s8_d2), .quo(qx)
  );

  rwh_divider #(.NW(53), .DW(35), .QW(18)) u_div_y (
    .clk(clk), .en(adv), .num(s8_ny), .den(s8_d2), .quo(qy)
  );

  logic [COORD_W-1:0] rx0_d, ry0_d, vx_d, vy_d;
  logic               xneg_d, yneg_d;

  rwh_delay #(.W(2*COORD_W), .DEPTH(25)) u_dly_r0 (
    .clk(clk), .en(adv), .d({s1_rx0, s1_ry0}), .q({rx0_d, ry0_d})
  );

  rwh_delay #(.W(2*COORD_W), .DEPTH(26)) u_dly_v (
    .clk(clk), .en(adv), .d({s1_vx, s1_vy}), .q({vx_d, vy_d})
  );

  rwh_delay #(.W(2), .DEPTH(19)) u_dly_neg (
    .clk(clk), .en(adv), .d({s7_xneg, s7_yneg}), .q({xneg_d, yneg_d})
  );

  // Stage 27: crossing point.
  logic [COORD_W-1:0] s27_cx, s27_cy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s27_cx <= xneg_d ? rx0_d - qx[15:0] : rx0_d + qx[15:0];
      s27_cy <= yneg_d ? ry0_d - qy[15:0] : ry0_d + qy[15:0];
    end
  end

  // Stages 28 to 30: squared distance to the viewer.
  logic signed [16:0] s28_ox, s28_oy;
  logic signed [33:0] s29_sx, s29_sy;
  logic [33:0]        s30_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      s28_ox <= $signed({s27_cx[15], s27_cx}) - $signed({vx_d[15], vx_d});
      s28_oy <= $signed({s27_cy[15], s27_cy}) - $signed({vy_d[15], vy_d});
      s29_sx <= s28_ox * s28_ox;
      s29_sy <= s28_oy * s28_oy;
      s30_s  <= 34'(s29_sx[32:0]) + 34'(s29_sy[32:0]);
    end
  end

  logic [DIST_W-1:0] dist_root;

  rwh_sqrt #(.RW(DIST_W)) u_sqrt (
    .clk(clk), .en(adv), .radicand(s30_s), .root(dist_root)
  );

  logic [LEN_W-1:0] len_d;

  rwh_delay #(.W(LEN_W), .DEPTH(47)) u_dly_len (
    .clk(clk), .en(adv), .d(s1_len), .q(len_d)
  );

  // Stage 49: bar height, bar top and the shade cutoff.
  logic [15:0]             len16;
  logic signed [BAR_H_W-1:0] s49_bh;
  logic [DIST_W-1:0]       s49_bary;
  logic                    s49_zero;
  logic [15:0]             s49_len16;

  assign len16 = {len_d, 4'b0000};

  always_ff @(posedge clk) begin
    if (adv) begin
      s49_bh    <= $signed(BAR_H_W'(len16)) - $signed(BAR_H_W'(dist_root));
      s49_bary  <= BAR_Y_BASE + DIST_W'((BAR_H_W'(dist_root) + BAR_H_W'(1)) >> 1);
      s49_zero  <= (DIST_W'(len16) <= dist_root);
      s49_len16 <= len16;
    end
  end

  // Stage 50: shade numerator.
  logic [23:0] s50_num;
  logic [15:0] s50_len16;

  always_ff @(posedge clk) begin
    if (adv) begin
      s50_num   <= s49_bh[15:0] * SHADE_MAX;
      s50_len16 <= s49_len16;
    end
  end

  logic [SHADE_W-1:0] shade_q;

  rwh_divider #(.NW(24), .DW(16), .QW(SHADE_W)) u_div_shade (
    .clk(clk), .en(adv), .num(s50_num), .den(s50_len16), .quo(shade_q)
  );

  // Bar width and bar left edge, computed alongside.
  logic [PARAM_W-1:0] width_q;
  logic [COL_W-1:0]   col_d;
  logic [23:0]        s15_barx;

  rwh_divider #(.NW(PARAM_W), .DW(CNT_W), .QW(PARAM_W)) u_div_width (
    .clk(clk), .en(adv), .num(VIEW_WIDTH), .den(s1_cnt), .quo(width_q)
  );

  rwh_delay #(.W(COL_W), .DEPTH(13)) u_dly_col (
    .clk(clk), .en(adv), .d(s1_col), .q(col_d)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s15_barx <= 24'(SCREEN_RIGHT) - 24'(col_d * width_q);
    end
  end

  logic                  hit_d;
  logic [COORD_W-1:0]    cx_d, cy_d;
  logic [DIST_W-1:0]     dist_d, bary_d;
  logic [BAR_H_W-1:0]    bh_d;
  logic                  zero_d;
  logic [PARAM_W-1:0]    width_d;
  logic [BAR_X_W-1:0]    barx_d;

  rwh_delay #(.W(1), .DEPTH(53)) u_dly_hit (
    .clk(clk), .en(adv), .d(s5_hit), .q(hit_d)
  );

  rwh_delay #(.W(2*COORD_W), .DEPTH(31)) u_dly_cross (
    .clk(clk), .en(adv), .d({s27_cx, s27_cy}), .q({cx_d, cy_d})
  );

  rwh_delay #(.W(DIST_W), .DEPTH(10)) u_dly_dist (
    .clk(clk), .en(adv), .d(dist_root), .q(dist_d)
  );

  rwh_delay #(.W(DIST_W + BAR_H_W + 1), .DEPTH(9)) u_dly_bar (
    .clk(clk), .en(adv), .d({s49_bary, s49_bh, s49_zero}),
    .q({bary_d, bh_d, zero_d})
  );

  rwh_delay #(.W(PARAM_W), .DEPTH(44)) u_dly_width (
    .clk(clk), .en(adv), .d(width_q), .q(width_d)
  );

  rwh_delay #(.W(BAR_X_W), .DEPTH(43)) u_dly_barx (
    .clk(clk), .en(adv), .d(s15_barx[BAR_X_W-1:0]), .q(barx_d)
  );

  // Output register.
  logic [SHADE_W-1:0] shade;

  assign shade = zero_d ? '0 : shade_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tuser <= hit_d;
      if (hit_d) begin
        m_axis_tdata <= {5'b0, shade, bh_d, width_d[COL_W-1:0], bary_d, barx_d,
                         dist_d, cy_d, cx_d};
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result carries nonzero fields");

  a_bar_y: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[86:70] ==
        BAR_Y_BASE + DIST_W'((BAR_H_W'(m_axis_tdata[48:32]) + BAR_H_W'(1)) >> 1))
    else $error("bar_y does not follow distance");

  a_shade_height: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[122:115] != '0 |->
      !m_axis_tdata[114] && m_axis_tdata[114:97] != '0)
    else $error("nonzero shade with bar height not positive");

  a_valid_moves: assert property (@(posedge clk) disable iff (rst)
    adv |=> vld[PIPE_DEPTH-1] == $past(vld[PIPE_DEPTH-2]))
    else $error("valid bit lost or invented in pipeline");

endmodule

// ===== tb/tb_ray_wall_hit_column.sv =====
module tb_ray_wall_hit_column;
  import rwh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]  column_number;
    logic [15:0] viewer_y;
    logic [15:0] viewer_x;
    logic [15:0] wall_end_y;
    logic [15:0] wall_end_x;
    logic [15:0] wall_start_y;
    logic [15:0] wall_start_x;
    logic [15:0] ray_end_y;
    logic [15:0] ray_end_x;
    logic [15:0] ray_start_y;
    logic [15:0] ray_start_x;
  } segment_pair_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  shade;
    logic [17:0] bar_height;
    logic [9:0]  bar_width;
    logic [16:0] bar_y;
    logic [20:0] bar_x;
    logic [16:0] distance;
    logic [15:0] cross_y;
    logic [15:0] cross_x;
  } column_bar_t;

  // Floor of n / d for d > 0.
  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint nearest_quot(longint n, longint d);
    return floor_quot(2 * n + d, 2 * d);
  endfunction

  function automatic longint unsigned sqrt_nearest(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r = r + 1;
    return r;
  endfunction

  class bar_scoreboard;
    logic [LEN_W-1:0] ray_length;
    logic [CNT_W-1:0] ray_count;
    column_bar_t pending_bars[$];
    int errors;
    int hits;
    int checked;

    function new();
      ray_length = LEN_RESET;
      ray_count = CNT_RESET;
      errors = 0;
      hits = 0;
      checked = 0;
    endfunction

    function void note_pair(segment_pair_t p);
      longint rx0, ry0, wx0, wy0, dxr, dyr, dxw, dyw, ex, ey;
      longint den, tn, un, cx, cy, ox, oy, cnt, wid, len16, shd, dist_v;
      column_bar_t b;
      b = '0;
      rx0 = $signed(p.ray_start_x);
      ry0 = $signed(p.ray_start_y);
      wx0 = $signed(p.wall_start_x);
      wy0 = $signed(p.wall_start_y);
      dxr = longint'($signed(p.ray_end_x)) - rx0;
      dyr = longint'($signed(p.ray_end_y)) - ry0;
      dxw = longint'($signed(p.wall_end_x)) - wx0;
      dyw = longint'($signed(p.wall_end_y)) - wy0;
      ex = wx0 - rx0;
      ey = wy0 - ry0;
      den = dxr * dyw - dyr * dxw;
      tn = ex * dyw - ey * dxw;
      un = ex * dyr - ey * dxr;
      if (den < 0) begin
        den = -den;
        tn = -tn;
        un = -un;
      end
      if (den != 0 && tn >= 0 && tn <= den && un >= 0 && un <= den) begin
        cx = rx0 + nearest_quot(dxr * tn, den);
        cy = ry0 + nearest_quot(dyr * tn, den);
        ox = cx - longint'($signed(p.viewer_x));
        oy = cy - longint'($signed(p.viewer_y));
        dist_v = longint'(sqrt_nearest(ox * ox + oy * oy));
        cnt = (ray_count == 0) ? 1 : ray_count;
        wid = 1000 / cnt;
        len16 = longint'(ray_length) * 16;
        shd = (dist_v >= len16) ? 0 : (255 * (len16 - dist_v)) / len16;
        b.hit = 1'b1;
        b.cross_x = cx[15:0];
        b.cross_y = cy[15:0];
        b.distance = dist_v[16:0];
        b.bar_x = 21'(2000 - longint'(p.column_number) * wid);
        b.bar_y = 17'(1600 + ((dist_v + 1) >> 1));
        b.bar_width = wid[9:0];
        b.bar_height = 18'(len16 - dist_v);
        b.shade = shd[7:0];
      end
      pending_bars.push_back(b);
    endfunction

    function void check_bar(column_bar_t a);
      column_bar_t e;
      if (pending_bars.size() == 0) begin
        $error("result with nothing expected: hit=%0d", a.hit);
        errors++;
        return;
      end
      e = pending_bars.pop_front();
      checked++;
      if (e.hit) hits++;
      if (a.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
      end
      if (a.cross_x !== e.cross_x) begin
        $error("cross_x exp %0h got %0h", e.cross_x, a.cross_x); errors++;
      end
      if (a.cross_y !== e.cross_y) begin
        $error("cross_y exp %0h got %0h", e.cross_y, a.cross_y); errors++;
      end
      if (a.distance !== e.distance) begin
        $error("distance exp %0d got %0d", e.distance, a.distance); errors++;
      end
      if (a.bar_x !== e.bar_x) begin
        $error("bar_x exp %0h got %0h", e.bar_x, a.bar_x); errors++;
      end
      if (a.bar_y !== e.bar_y) begin
        $error("bar_y exp %0d got %0d", e.bar_y, a.bar_y); errors++;
      end
      if (a.bar_width !== e.bar_width) begin
        $error("bar_width exp %0d got %0d", e.bar_width, a.bar_width); errors++;
      end
      if (a.bar_height !== e.bar_height) begin
        $error("bar_height exp %0h got %0h", e.bar_height, a.bar_height); errors++;
      end
      if (a.shade !== e.shade) begin
        $error("shade exp %0d got %0d", e.shade, a.shade); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [LEN_W-1:0] cfg_data;

  bar_scoreboard bars;
  longint cycle_count;

  ray_wall_hit_column dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RAY_LENGTH;
    cfg_data = '0;
    rst = 1'b1;
    bars = new();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end
  initial cycle_count = 0;

  // Output side: random stalls, and each accepted transaction is checked.
  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      bars.check_bar({m_axis_tuser, m_axis_tdata[122:0]});
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [LEN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_RAY_LENGTH) bars.ray_length = val;
    else bars.ray_count = val[CNT_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays high after a transaction; it drops only before an idle gap.
  task automatic send_pair(segment_pair_t p, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'(p);
    do @(posedge clk); while (!s_axis_tready);
    bars.note_pair(p);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (bars.pending_bars.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 2000)) - 1000);
      default: return 16'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // Builds a pair that usually crosses: the wall passes through a point on the ray.
  function automatic segment_pair_t crossing_pair(int mode);
    segment_pair_t p;
    longint ax, ay, bx, by, px, py;
    int k;
    p.ray_start_x = rand_coord(mode);
    p.ray_start_y = rand_coord(mode);
    p.ray_end_x = rand_coord(mode);
    p.ray_end_y = rand_coord(mode);
    ax = $signed(p.ray_start_x); ay = $signed(p.ray_start_y);
    bx = $signed(p.ray_end_x); by = $signed(p.ray_end_y);
    k = $urandom_range(0, 16);
    px = ax + (bx - ax) * k / 16;
    py = ay + (by - ay) * k / 16;
    ax = $signed(16'($urandom_range(0, 400))) - 200;
    ay = $signed(16'($urandom_range(0, 400))) - 200;
    p.wall_start_x = 16'(px - ax);
    p.wall_start_y = 16'(py - ay);
    p.wall_end_x = 16'(px + ax);
    p.wall_end_y = 16'(py + ay);
    p.viewer_x = rand_coord(mode);
    p.viewer_y = rand_coord(mode);
    p.column_number = ($urandom_range(0, 9) == 0) ? 10'($urandom) :
                      10'($urandom_range(1, 1000));
    return p;
  endfunction

  function automatic segment_pair_t make_pair(int rx0, int ry0, int rx1, int ry1,
      int wx0, int wy0, int wx1, int wy1, int vx, int vy, int col);
    segment_pair_t p;
    p.ray_start_x = 16'(rx0); p.ray_start_y = 16'(ry0);
    p.ray_end_x = 16'(rx1);   p.ray_end_y = 16'(ry1);
    p.wall_start_x = 16'(wx0); p.wall_start_y = 16'(wy0);
    p.wall_end_x = 16'(wx1);   p.wall_end_y = 16'(wy1);
    p.viewer_x = 16'(vx); p.viewer_y = 16'(vy);
    p.column_number = 10'(col);
    return p;
  endfunction

  initial begin
    segment_pair_t p;
    int n;
    logic [LEN_W-1:0] lengths[6];
    logic [LEN_W-1:0] counts[6];
    lengths = '{12'd256, 12'd1, 12'd4095, 12'd0, 12'd40, 12'd700};
    counts = '{12'd64, 12'd1, 12'd1000, 12'd0, 12'd1023, 12'd7};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: plain cross, parallel, collinear, degenerate, vertical ray and
    // wall, touching ends, extremes of the coordinates and columns.
    send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0, 0, 0, 1), 0);
    send_pair(make_pair(0, 0, 160, 0, 0, 16, 160, 16, 0, 0, 2), 0);
    send_pair(make_pair(0, 0, 160, 0, 32, 0, 320, 0, 0, 0, 3), 0);
    send_pair(make_pair(5, 5, 5, 5, 0, 0, 16, 16, 0, 0, 4), 0);
    send_pair(make_pair(80, -160, 80, 160, 0, 0, 320, 32, 0, 0, 5), 0);
    send_pair(make_pair(0, 0, 320, 32, 80, -160, 80, 160, 7, -9, 6), 0);
    send_pair(make_pair(80, 0, 80, 160, 80, 200, 80, 400, 0, 0, 7), 0);
    send_pair(make_pair(0, 0, 160, 0, 160, 0, 160, 160, 0, 0, 8), 0);
    send_pair(make_pair(0, 0, 160, 0, 161, -5, 161, 5, 0, 0, 9), 0);
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                        32767, 32767, 1000), 0);
    send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767, -32768, -32768,
                        1023), 0);
    send_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0, 0, 0, 0), 0);
    send_pair(make_pair(0, 0, 3, 0, 1, -1, 2, 2, -1, -1, 512), 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_RAY_LENGTH, lengths[ph]);
      write_reg(REG_RAY_COUNT, counts[ph]);
      send_pair(make_pair(0, 0, 64000, 0, 4000, -16, 4000, 16, 0, 0, 10), 0);
      n = (ph == 0) ? 400 : 190;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: begin
            p = 170'({$urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom});
          end
          1: p = crossing_pair(0);
          2, 3: p = crossing_pair(2);
          default: p = crossing_pair(1);
        endcase
        send_pair(p, $urandom_range(0, 3) == 0);
        if (i == 100) begin
          // Hold off until the pipeline has delivered everything.
          s_axis_tvalid <= 1'b0;
          while (bars.pending_bars.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Checked %0d results (%0d hits) over six register settings.",
             bars.checked, bars.hits);
    if (bars.errors == 0 && bars.pending_bars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
